// ===== rtl/integer_field_formatter_unit_defines.svh =====
// Assertion macros used by the formatter RTL (iff_emit).
`ifndef INTEGER_FIELD_FORMATTER_UNIT_DEFINES_SVH
`define INTEGER_FIELD_FORMATTER_UNIT_DEFINES_SVH

// Same-cycle implication, checked out of reset.
`define IFF_ASSERT_NOW(lbl, ante, cons) \
   lbl: assert property (@(posedge clock) disable iff (reset) (ante) |-> (cons)) \
      else $error("formatter check failed");

// Next-cycle implication, checked out of reset.
`define IFF_ASSERT_NEXT(lbl, ante, cons) \
   lbl: assert property (@(posedge clock) disable iff (reset) (ante) |=> (cons)) \
      else $error("formatter check failed");

`endif

// ===== rtl/iff_pkg.sv =====
// Types, constants and helpers of the integer field formatter.
`timescale 1ns / 1ps
package iff_pkg;

   localparam int MAX_FIELD_DEF  = 96;
   localparam int VALUE_BITS_DEF = 64;
   localparam int VALUE_W        = 64;
   localparam int FIELD_W        = 7;

   localparam logic [2:0] ACT_SDEC = 3'd0;
   localparam logic [2:0] ACT_UDEC = 3'd1;
   localparam logic [2:0] ACT_HEXL = 3'd2;
   localparam logic [2:0] ACT_HEXU = 3'd3;
   localparam logic [2:0] ACT_BIN  = 3'd4;
   localparam logic [2:0] ACT_PTR  = 3'd5;

   localparam logic [2:0] SZ_INT   = 3'd0;
   localparam logic [2:0] SZ_LONG  = 3'd1;
   localparam logic [2:0] SZ_LLONG = 3'd2;
   localparam logic [2:0] SZ_SIZE  = 3'd3;
   localparam logic [2:0] SZ_SHORT = 3'd4;
   localparam logic [2:0] SZ_CHAR  = 3'd5;

   localparam logic [7:0] CH_SPACE = 8'h20;
   localparam logic [7:0] CH_PLUS  = 8'h2B;
   localparam logic [7:0] CH_MINUS = 8'h2D;
   localparam logic [7:0] CH_ZERO  = 8'h30;
   localparam logic [7:0] CH_UA    = 8'h41;
   localparam logic [7:0] CH_LA    = 8'h61;
   localparam logic [7:0] CH_XU    = 8'h58;
   localparam logic [7:0] CH_XL    = 8'h78;
   localparam logic [7:0] CH_BL    = 8'h62;

   typedef enum logic [1:0] {
      RADIX_DEC,
      RADIX_HEX,
      RADIX_BIN
   } radix_type;

   typedef enum logic [2:0] {
      ST_IDLE,
      ST_LOAD,
      ST_CONV,
      ST_NORM,
      ST_EMIT
   } state_type;

   typedef struct packed {
      logic load;
      logic dabble;
      logic norm;
   } conv_cmd_type;

   typedef struct packed {
      logic [FIELD_W-1:0] width;
      logic [FIELD_W-1:0] prec;
      logic               zpad;
      logic               left;
      logic [1:0]         plen;
      logic [7:0]         lead0;
      logic [7:0]         lead1;
      logic               upper;
   } fmt_type;

   function automatic logic [7:0] digit_char(input logic [3:0] d, input logic upper);
      logic [7:0] c;
      if (d < 4'd10) begin
         c = CH_ZERO + {4'b0, d};
      end else if (upper) begin
         c = CH_UA + {4'b0, d - 4'd10};
      end else begin
         c = CH_LA + {4'b0, d - 4'd10};
      end
      return c;
   endfunction

endpackage

// ===== rtl/iff_conv.sv =====
// Digit register: loads the magnitude, runs double dabble, strips leading zeros.
`timescale 1ns / 1ps
module iff_conv #(
   parameter int VALUE_BITS = iff_pkg::VALUE_BITS_DEF
) (
   input  logic                             clock,
   input  iff_pkg::conv_cmd_type            cmd,
   input  iff_pkg::radix_type               radix,
   input  logic [VALUE_BITS-1:0]            mag,
   input  logic                             pop,
   output logic [3:0]                       top_digit,
   output logic                             top_zero,
   output logic [$clog2(VALUE_BITS+1)-1:0]  digit_count
);
   import iff_pkg::*;

   localparam int SLOTS = VALUE_BITS;
   localparam int HEXD  = (VALUE_BITS + 3) / 4;
   localparam int DECD  = (VALUE_BITS * 77) / 256 + 1;
   localparam int NW    = $clog2(VALUE_BITS + 1);

   logic [SLOTS-1:0][3:0]  slot_ff, slot_in;
   logic [VALUE_BITS-1:0]  mag_ff, mag_in;
   logic [NW-1:0]          n_ff, n_in;
   logic [HEXD*4-1:0]      mag_pad;
   logic [DECD-1:0][3:0]   adj;

   always_comb begin
      mag_pad = (HEXD*4)'(mag);
      for (int i = 0; i < DECD; i++) begin
         adj[i] = (slot_ff[i] >= 4'd5) ? slot_ff[i] + 4'd3 : slot_ff[i];
      end
   end

   always_comb begin
      slot_in = slot_ff;
      mag_in  = mag_ff;
      n_in    = n_ff;
      if (cmd.load) begin
         mag_in = mag;
         n_in   = NW'(SLOTS);
         for (int i = 0; i < SLOTS; i++) begin
            slot_in[i] = 4'd0;
         end
         case (radix)
            RADIX_BIN: begin
               for (int i = 0; i < SLOTS; i++) begin
                  slot_in[i] = {3'b0, mag[i]};
               end
            end
            RADIX_HEX: begin
               for (int i = 0; i < HEXD; i++) begin
                  slot_in[i] = mag_pad[4*i +: 4];
               end
            end
            default: begin
            end
         endcase
      end else if (cmd.dabble) begin
         // correct each BCD digit, then shift the next value bit in
         slot_in[0] = {adj[0][2:0], mag_ff[VALUE_BITS-1]};
         for (int i = 1; i < DECD; i++) begin
            slot_in[i] = {adj[i][2:0], adj[i-1][3]};
         end
         mag_in = mag_ff << 1;
      end else if (cmd.norm || pop) begin
         for (int i = 1; i < SLOTS; i++) begin
            slot_in[i] = slot_ff[i-1];
         end
         slot_in[0] = 4'd0;
         if (cmd.norm) begin
            n_in = n_ff - NW'(1);
         end
      end
   end

   always_ff @(posedge clock) begin
      slot_ff <= slot_in;
      mag_ff  <= mag_in;
      n_ff    <= n_in;
   end

   assign top_digit   = slot_ff[SLOTS-1];
   assign top_zero    = (slot_ff[SLOTS-1] == 4'd0);
   assign digit_count = n_ff;

endmodule

// ===== rtl/iff_emit.sv =====
// Field sizing, character sequencer and two-character output register.
`timescale 1ns / 1ps
`include "integer_field_formatter_unit_defines.svh"
module iff_emit #(
   parameter int MAX_FIELD  = iff_pkg::MAX_FIELD_DEF,
   parameter int VALUE_BITS = iff_pkg::VALUE_BITS_DEF
) (
   input  logic                             clock,
   input  logic                             reset,
   input  logic                             start,
   input  iff_pkg::fmt_type                 fmt,
   input  logic [$clog2(VALUE_BITS+1)-1:0]  digit_count,
   input  logic [3:0]                       digit,
   output logic                             pop,
   output logic                             done,
   output logic                             rsp_valid,
   input  logic                             rsp_ready,
   output logic [7:0]                       rsp_char_first,
   output logic [7:0]                       rsp_char_second,
   output logic [1:0]                       rsp_char_count,
   output logic                             rsp_last_of_run
);
   import iff_pkg::*;

   localparam int LW = $clog2(MAX_FIELD + VALUE_BITS + 3);

   fmt_type        fmt_ff, fmt_in;
   logic [LW-1:0]  n_ff, n_in, zeros_ff, zeros_in, pad_ff, pad_in;
   logic [LW-1:0]  b1_ff, b1_in, b2_ff, b2_in, b3_ff, b3_in, b4_ff, b4_in;
   logic [LW-1:0]  end_ff, end_in, pos_ff, pos_in;
   logic           prep_ff, prep_in, run_ff, run_in;
   logic           half_v_ff, half_v_in;
   logic [7:0]     half_ch_ff, half_ch_in;
   logic           out_v_ff, out_v_in;
   logic [7:0]     out_a_ff, out_a_in, out_b_ff, out_b_in;
   logic [1:0]     out_cnt_ff, out_cnt_in;
   logic           out_last_ff, out_last_in;

   logic [LW-1:0]  w_x, p_x, n_x, pl_x, body, zeros_c, total_c, b3_c;
   logic           out_free, last, step, in_dig;
   logic [7:0]     ch;

   // sizing, taken at start
   always_comb begin
      w_x  = LW'(fmt.width);
      p_x  = LW'(fmt.prec);
      n_x  = LW'(digit_count);
      pl_x = LW'(fmt.plen);
      body = n_x + pl_x;
      if (p_x > n_x) begin
         zeros_c = p_x - n_x;
      end else if (fmt.zpad && (w_x > body)) begin
         zeros_c = w_x - body;
      end else begin
         zeros_c = '0;
      end
      total_c = body + zeros_c;
   end

   assign b3_c = b2_ff + zeros_ff;

   // character at the current position
   always_comb begin
      in_dig = 1'b0;
      if (pos_ff < b1_ff) begin
         ch = CH_SPACE;
      end else if (pos_ff < b2_ff) begin
         ch = (pos_ff == b1_ff) ? fmt_ff.lead0 : fmt_ff.lead1;
      end else if (pos_ff < b3_ff) begin
         ch = CH_ZERO;
      end else if (pos_ff < b4_ff) begin
         ch     = digit_char(digit, fmt_ff.upper);
         in_dig = 1'b1;
      end else begin
         ch = CH_SPACE;
      end
   end

   assign out_free = !out_v_ff || rsp_ready;
   assign last     = (pos_ff + LW'(1) == end_ff);
   assign step     = run_ff && (half_v_ff ? out_free : (!last || out_free));
   assign pop      = step && in_dig;
   assign done     = step && last;

   always_comb begin
      fmt_in      = fmt_ff;
      n_in        = n_ff;
      zeros_in    = zeros_ff;
      pad_in      = pad_ff;
      b1_in       = b1_ff;
      b2_in       = b2_ff;
      b3_in       = b3_ff;
      b4_in       = b4_ff;
      end_in      = end_ff;
      pos_in      = pos_ff;
      prep_in     = 1'b0;
      run_in      = run_ff;
      half_v_in   = half_v_ff;
      half_ch_in  = half_ch_ff;
      out_v_in    = out_v_ff && !rsp_ready;
      out_a_in    = out_a_ff;
      out_b_in    = out_b_ff;
      out_cnt_in  = out_cnt_ff;
      out_last_in = out_last_ff;
      if (start) begin
         fmt_in   = fmt;
         n_in     = n_x;
         zeros_in = zeros_c;
         pad_in   = (w_x > total_c) ? w_x - total_c : '0;
         prep_in  = 1'b1;
      end
      if (prep_ff) begin
         b1_in     = fmt_ff.left ? '0 : pad_ff;
         b2_in     = (fmt_ff.left ? '0 : pad_ff) + LW'(fmt_ff.plen);
         b3_in     = '0;
         b4_in     = '0;
         pos_in    = '0;
         run_in    = 1'b0;
      end
      if (step) begin
         pos_in = pos_ff + LW'(1);
         if (!half_v_ff && !last) begin
            half_v_in  = 1'b1;
            half_ch_in = ch;
         end else begin
            out_v_in    = 1'b1;
            out_a_in    = half_v_ff ? half_ch_ff : ch;
            out_b_in    = half_v_ff ? ch : 8'd0;
            out_cnt_in  = half_v_ff ? 2'd2 : 2'd1;
            out_last_in = last;
            half_v_in   = 1'b0;
         end
         if (last) begin
            run_in = 1'b0;
         end
      end
   end

   // second prep cycle: finish the segment bounds and start running
   logic prep2_ff, prep2_in;
   always_comb begin
      prep2_in = prep_ff;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         prep_ff   <= 1'b0;
         prep2_ff  <= 1'b0;
         run_ff    <= 1'b0;
         half_v_ff <= 1'b0;
         out_v_ff  <= 1'b0;
      end else begin
         prep_ff   <= prep_in;
         prep2_ff  <= prep2_in;
         run_ff    <= prep2_ff ? 1'b1 : run_in;
         half_v_ff <= half_v_in;
         out_v_ff  <= out_v_in;
      end
   end

   always_ff @(posedge clock) begin
      fmt_ff      <= fmt_in;
      n_ff        <= n_in;
      zeros_ff    <= zeros_in;
      pad_ff      <= pad_in;
      b1_ff       <= b1_in;
      b2_ff       <= b2_in;
      b3_ff       <= prep2_ff ? b3_c : b3_in;
      b4_ff       <= prep2_ff ? b3_c + n_ff : b4_in;
      end_ff      <= prep2_ff ? b3_c + n_ff + (fmt_ff.left ? pad_ff : '0) : end_in;
      pos_ff      <= pos_in;
      half_ch_ff  <= half_ch_in;
      out_a_ff    <= out_a_in;
      out_b_ff    <= out_b_in;
      out_cnt_ff  <= out_cnt_in;
      out_last_ff <= out_last_in;
   end

   assign rsp_valid       = out_v_ff;
   assign rsp_char_first  = out_a_ff;
   assign rsp_char_second = out_b_ff;
   assign rsp_char_count  = out_cnt_ff;
   assign rsp_last_of_run = out_last_ff;

   `IFF_ASSERT_NOW(a_single_is_last, out_v_ff && (out_cnt_ff != 2'd2), out_last_ff)
   `IFF_ASSERT_NOW(a_pos_in_field, run_ff, pos_ff < end_ff)
   `IFF_ASSERT_NOW(a_start_when_free, start, !run_ff && !prep_ff && !prep2_ff)
   `IFF_ASSERT_NEXT(a_done_clears_half, done, !half_v_ff && !run_ff)

endmodule

// ===== rtl/integer_field_formatter_unit.sv =====
// Top level of the integer field formatter: input capture and sequencing.
`timescale 1ns / 1ps
//
//  channel | direction | handshake         | payload
//  req     | in        | req_valid/ready   | action, value, size mode, flags, width, precision
//  rsp     | out       | rsp_valid/ready   | two characters, count, last of run
//
//  One field at a time. After the word is taken: a load step, double dabble
//  for decimal, stripping of leading zero digits, sizing (prep, then second
//  prep), then one character per cycle while the result is not stalled
//  (two per result word), the character sequencer setting the pace.
//  Reset is synchronous and clears all control state; the digit register
//  needs none. A stalled result holds the sequencer; the next word is taken
//  as soon as the last character is in the output register.
module integer_field_formatter_unit #(
   parameter int MAX_FIELD  = iff_pkg::MAX_FIELD_DEF,
   parameter int VALUE_BITS = iff_pkg::VALUE_BITS_DEF
) (
   input  logic                          clock,
   input  logic                          reset,
   input  logic                          req_valid,
   output logic                          req_ready,
   input  logic [2:0]                    req_action,
   input  logic [iff_pkg::VALUE_W-1:0]   req_value,
   input  logic [2:0]                    req_size_mode,
   input  logic                          req_left_align,
   input  logic                          req_show_sign,
   input  logic                          req_space_sign,
   input  logic                          req_zero_pad,
   input  logic                          req_alt_form,
   input  logic [iff_pkg::FIELD_W-1:0]   req_field_width,
   input  logic                          req_has_precision,
   input  logic [iff_pkg::FIELD_W-1:0]   req_precision_digits,
   output logic                          rsp_valid,
   input  logic                          rsp_ready,
   output logic [7:0]                    rsp_char_first,
   output logic [7:0]                    rsp_char_second,
   output logic [1:0]                    rsp_char_count,
   output logic                          rsp_last_of_run
);
   import iff_pkg::*;

   localparam int BW = $clog2(VALUE_BITS + 1);
   localparam int IW = $clog2(VALUE_BITS);
   localparam logic [BW-1:0] B64 = BW'(VALUE_BITS);
   localparam logic [BW-1:0] B32 = BW'((VALUE_BITS < 32) ? VALUE_BITS : 32);
   localparam logic [BW-1:0] B16 = BW'((VALUE_BITS < 16) ? VALUE_BITS : 16);
   localparam logic [BW-1:0] B8  = BW'(8);
   localparam logic [FIELD_W-1:0] MAXF = FIELD_W'(MAX_FIELD);

   state_type              state_ff, state_in;
   logic [BW-1:0]          cnt_ff, cnt_in;
   radix_type              radix_ff, radix_in;
   logic [VALUE_BITS-1:0]  val_ff, val_in, mask_ff, mask_in;
   logic                   neg_ff, neg_in;
   fmt_type                fmt_ff, fmt_in;

   radix_type              radix_c;
   logic [BW-1:0]          bits_c;
   logic [IW-1:0]          sidx;
   logic [VALUE_BITS-1:0]  vmask;
   logic                   neg_c;
   fmt_type                fmt_c;
   logic [VALUE_BITS-1:0]  mag;
   conv_cmd_type           cmd;
   logic                   accept, norm_more, start, done, pop, top_zero;
   logic [3:0]             top_digit;
   logic [BW-1:0]          digit_count;

   assign accept = req_valid && req_ready;

   // decode the incoming word
   always_comb begin
      case (req_action)
         ACT_HEXL, ACT_HEXU, ACT_PTR: radix_c = RADIX_HEX;
         ACT_BIN:                     radix_c = RADIX_BIN;
         default:                     radix_c = RADIX_DEC;
      endcase
      if (req_action == ACT_PTR) begin
         bits_c = B64;
      end else begin
         case (req_size_mode)
            SZ_LONG, SZ_LLONG, SZ_SIZE: bits_c = B64;
            SZ_SHORT:                   bits_c = B16;
            SZ_CHAR:                    bits_c = B8;
            default:                    bits_c = B32;
         endcase
      end
      for (int i = 0; i < VALUE_BITS; i++) begin
         mask_in[i] = (BW'(i) < bits_c);
      end
      vmask = req_value[VALUE_BITS-1:0] & mask_in;
      sidx  = IW'(bits_c - BW'(1));
      neg_c = (req_action == ACT_SDEC) && vmask[sidx];

      fmt_c.width = (req_field_width > MAXF) ? MAXF : req_field_width;
      fmt_c.prec  = !req_has_precision ? '0 :
                    (req_precision_digits > MAXF) ? MAXF : req_precision_digits;
      fmt_c.left  = req_left_align;
      fmt_c.zpad  = req_zero_pad && !req_left_align;
      fmt_c.upper = (req_action == ACT_HEXU);
      fmt_c.plen  = 2'd0;
      fmt_c.lead0 = CH_ZERO;
      fmt_c.lead1 = CH_XL;
      if (req_action == ACT_SDEC) begin
         if (neg_c) begin
            fmt_c.plen  = 2'd1;
            fmt_c.lead0 = CH_MINUS;
         end else if (req_show_sign) begin
            fmt_c.plen  = 2'd1;
            fmt_c.lead0 = CH_PLUS;
         end else if (req_space_sign) begin
            fmt_c.plen  = 2'd1;
            fmt_c.lead0 = CH_SPACE;
         end
      end else if ((req_action == ACT_PTR) || (req_alt_form && ((req_action == ACT_HEXL)
                   || (req_action == ACT_HEXU) || (req_action == ACT_BIN)))) begin
         fmt_c.plen  = 2'd2;
         fmt_c.lead0 = CH_ZERO;
         fmt_c.lead1 = (req_action == ACT_HEXU) ? CH_XU :
                       (req_action == ACT_BIN) ? CH_BL : CH_XL;
      end
   end

   always_comb begin
      radix_in = radix_ff;
      val_in   = val_ff;
      neg_in   = neg_ff;
      fmt_in   = fmt_ff;
      if (accept) begin
         radix_in = radix_c;
         val_in   = vmask;
         neg_in   = neg_c;
         fmt_in   = fmt_c;
      end
   end

   assign mag       = neg_ff ? ((~val_ff + VALUE_BITS'(1)) & mask_ff) : val_ff;
   assign norm_more = top_zero && (digit_count > BW'(1));

   // next state
   always_comb begin
      state_in = state_ff;
      case (state_ff)
         ST_IDLE: if (req_valid) state_in = ST_LOAD;
         ST_LOAD: state_in = (radix_ff == RADIX_DEC) ? ST_CONV : ST_NORM;
         ST_CONV: if (cnt_ff == BW'(VALUE_BITS - 1)) state_in = ST_NORM;
         ST_NORM: if (!norm_more) state_in = ST_EMIT;
         ST_EMIT: if (done) state_in = ST_IDLE;
         default: state_in = ST_IDLE;
      endcase
   end

   // outputs of the sequencer
   always_comb begin
      req_ready  = 1'b0;
      cmd.load   = 1'b0;
      cmd.dabble = 1'b0;
      cmd.norm   = 1'b0;
      start      = 1'b0;
      cnt_in     = cnt_ff;
      case (state_ff)
         ST_IDLE: req_ready = 1'b1;
         ST_LOAD: begin
            cmd.load = 1'b1;
            cnt_in   = '0;
         end
         ST_CONV: begin
            cmd.dabble = 1'b1;
            cnt_in     = cnt_ff + BW'(1);
         end
         ST_NORM: begin
            cmd.norm = norm_more;
            start    = !norm_more;
         end
         default: begin
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_IDLE;
      end else begin
         state_ff <= state_in;
      end
   end

   always_ff @(posedge clock) begin
      cnt_ff   <= cnt_in;
      radix_ff <= radix_in;
      val_ff   <= val_in;
      mask_ff  <= accept ? mask_in : mask_ff;
      neg_ff   <= neg_in;
      fmt_ff   <= fmt_in;
   end

   iff_conv #(
      .VALUE_BITS (VALUE_BITS)
   ) u_conv (
      .clock       (clock),
      .cmd         (cmd),
      .radix       (radix_ff),
      .mag         (mag),
      .pop         (pop),
      .top_digit   (top_digit),
      .top_zero    (top_zero),
      .digit_count (digit_count)
   );

   iff_emit #(
      .MAX_FIELD  (MAX_FIELD),
      .VALUE_BITS (VALUE_BITS)
   ) u_emit (
      .clock           (clock),
      .reset           (reset),
      .start           (start),
      .fmt             (fmt_ff),
      .digit_count     (digit_count),
      .digit           (top_digit),
      .pop             (pop),
      .done            (done),
      .rsp_valid       (rsp_valid),
      .rsp_ready       (rsp_ready),
      .rsp_char_first  (rsp_char_first),
      .rsp_char_second (rsp_char_second),
      .rsp_char_count  (rsp_char_count),
      .rsp_last_of_run (rsp_last_of_run)
   );

endmodule
